// ----- rtl/decimated_sample_statistics_unit_defines.svh -----
`ifndef DECIMATED_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define DECIMATED_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define DSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define DSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dss_pkg.sv -----
`default_nettype none
package dss_pkg;

   localparam int DATA_W  = 32;
   localparam int SLEEP_W = 16;
   localparam int PROD_W  = 64;
   localparam int DEN_W   = 33;

   // Register file: one word per register
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SLEEP_FRAMES = 1'b0;

   // Serial divider status toward the sequencer
   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quotient;
   } div_status_type;

endpackage
`default_nettype wire

// ----- rtl/decimated_sample_statistics_unit.sv -----
`default_nettype none
// Channel  Ports           Direction  Moves
// req      req_valid/stall in         sample, clear
// rsp      rsp_valid/stall out        accepted, mean, min, max, count, slot
// csr      csr_p*          in/out     sleep_frames write and read back
//
// A kept sample passes from acceptance through multiply, add, divider start,
// 32 divider steps and quotient capture to the result load.
// Skipped or clear transactions pass through one history read state to the load.
// req_stall is high from acceptance until the result loads, so no new transaction
// is taken before the last is done; a stalled earlier result delays the load.
// Reset is synchronous and clears all statistics and sleep_frames.
module decimated_sample_statistics_unit #(
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [dss_pkg::DATA_W-1:0]   req_sample,
   input  wire logic                                req_clear,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_accepted,
   output      logic signed [dss_pkg::DATA_W-1:0]   rsp_mean_value,
   output      logic signed [dss_pkg::DATA_W-1:0]   rsp_min_value,
   output      logic signed [dss_pkg::DATA_W-1:0]   rsp_max_value,
   output      logic        [dss_pkg::DATA_W-1:0]   rsp_kept_count,
   output      logic signed [dss_pkg::DATA_W-1:0]   rsp_slot_value,
   output      logic                                rsp_slot_valid,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dss_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [dss_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output      logic [dss_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output      logic                                csr_pready
);

   localparam int DW    = dss_pkg::DATA_W;
   localparam int SW    = dss_pkg::SLEEP_W;
   localparam int PW    = dss_pkg::PROD_W;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_POST = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [SW-1:0]           sleep_ff, sleep_in;
   logic [SW-1:0]           skip_ff, skip_in;
   logic [IDX_W-1:0]        ring_ff, ring_in;
   logic                    wrapped_ff, wrapped_in;
   logic                    seeded_ff, seeded_in;
   logic signed [DW-1:0]    min_ff, min_in;
   logic signed [DW-1:0]    max_ff, max_in;
   logic signed [DW-1:0]    mean_ff, mean_in;
   logic [DW-1:0]           count_ff, count_in;
   logic                    start_ff, start_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [DW-1:0]              n_ff, n_in;
   logic [dss_pkg::DEN_W-1:0]  den_ff, den_in;
   logic signed [DW-1:0]       x_ff, x_in;
   logic                       kept_ff, kept_in;
   logic                       mneg_ff, mneg_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic signed [PW-1:0]       num_ff, num_in;
   logic signed [DW-1:0]       rd_ff;

   logic                       rsp_accepted_ff;
   logic signed [DW-1:0]       rsp_mean_ff, rsp_min_ff, rsp_max_ff, rsp_slot_ff;
   logic [DW-1:0]              rsp_count_ff;
   logic                       rsp_slot_valid_ff;

   logic signed [DW-1:0]       hist_mem [HISTORY_DEPTH];
   logic                       hist_we;
   logic                       keep;
   logic                       out_load;
   logic                       csr_write;
   logic [DW-1:0]              mean_mag;
   logic signed [PW-1:0]       x_ext;

   dss_pkg::div_status_type    div_status;

   dss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_ff),
      .divisor  (den_ff),
      .status   (div_status)
   );

   // Register file access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[dss_pkg::CSR_ADDR_W-1] == dss_pkg::REG_SLEEP_FRAMES);
   assign csr_prdata = (csr_paddr[dss_pkg::CSR_ADDR_W-1] == dss_pkg::REG_SLEEP_FRAMES)
                       ? dss_pkg::CSR_DATA_W'(sleep_ff) : '0;

   assign req_stall = (state_ff != S_IDLE);
   assign keep      = (sleep_ff == '0) || (skip_ff >= sleep_ff);
   assign out_load  = (state_ff == S_POST) && (!rsp_valid_ff || !rsp_stall);
   assign mean_mag  = mean_ff[DW-1] ? DW'(-mean_ff) : DW'(mean_ff);
   assign x_ext     = PW'(x_ff);

   // Sequencer and statistics update
   always_comb begin
      state_in     = state_ff;
      sleep_in     = csr_write ? csr_pwdata[SW-1:0] : sleep_ff;
      skip_in      = skip_ff;
      ring_in      = ring_ff;
      wrapped_in   = wrapped_ff;
      seeded_in    = seeded_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      count_in     = count_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      n_in         = n_ff;
      den_in       = den_ff;
      x_in         = x_ff;
      kept_in      = kept_ff;
      mneg_in      = mneg_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      hist_we      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in    = req_sample;
               kept_in = 1'b0;
               if (req_clear) begin
                  ring_in    = '0;
                  wrapped_in = 1'b0;
                  seeded_in  = 1'b0;
                  min_in     = '0;
                  max_in     = '0;
                  mean_in    = '0;
                  count_in   = '0;
                  skip_in    = '0;
                  state_in   = S_READ;
               end else if (keep) begin
                  kept_in  = 1'b1;
                  hist_we  = 1'b1;
                  if (sleep_ff != '0) begin
                     skip_in = '0;
                  end
                  n_in     = count_ff;
                  den_in   = dss_pkg::DEN_W'(count_ff) + 1'b1;
                  if (count_ff != '1) begin
                     count_in = DW'(count_ff + 1'b1);
                  end
                  if (!seeded_ff) begin
                     min_in = req_sample;
                     max_in = req_sample;
                  end else begin
                     if (req_sample < min_ff) begin
                        min_in = req_sample;
                     end
                     if (req_sample > max_ff) begin
                        max_in = req_sample;
                     end
                  end
                  seeded_in = 1'b1;
                  if (ring_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
                     ring_in    = '0;
                     wrapped_in = 1'b1;
                  end else begin
                     ring_in = IDX_W'(ring_ff + 1'b1);
                  end
                  state_in = S_MUL;
               end else begin
                  skip_in  = SW'(skip_ff + 1'b1);
                  state_in = S_READ;
               end
            end
         end
         S_MUL: begin
            // Multiply magnitudes; the sign comes back in with the add
            mneg_in  = mean_ff[DW-1];
            prod_in  = PW'(mean_mag * n_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            num_in   = mneg_ff ? x_ext - $signed(prod_ff) : x_ext + $signed(prod_ff);
            start_in = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               mean_in  = div_status.quotient;
               state_in = S_POST;
            end
         end
         S_READ: begin
            state_in = S_POST;
         end
         S_POST: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sleep_ff     <= '0;
         skip_ff      <= '0;
         ring_ff      <= '0;
         wrapped_ff   <= 1'b0;
         seeded_ff    <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sleep_ff     <= sleep_in;
         skip_ff      <= skip_in;
         ring_ff      <= ring_in;
         wrapped_ff   <= wrapped_in;
         seeded_ff    <= seeded_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      den_ff  <= den_in;
      x_ff    <= x_in;
      kept_ff <= kept_in;
      mneg_ff <= mneg_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
   end

   // History ring: write at the ring index, read the current index
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[ring_ff] <= req_sample;
      end
      rd_ff <= hist_mem[ring_ff];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_accepted_ff   <= kept_ff;
         rsp_mean_ff       <= mean_ff;
         rsp_min_ff        <= min_ff;
         rsp_max_ff        <= max_ff;
         rsp_count_ff      <= count_ff;
         rsp_slot_ff       <= wrapped_ff ? rd_ff : '0;
         rsp_slot_valid_ff <= wrapped_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_min_value  = rsp_min_ff;
   assign rsp_max_value  = rsp_max_ff;
   assign rsp_kept_count = rsp_count_ff;
   assign rsp_slot_value = rsp_slot_ff;
   assign rsp_slot_valid = rsp_slot_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/dss_div.sv -----
`default_nettype none
module dss_div (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic signed [dss_pkg::PROD_W-1:0]       dividend,
   input  wire logic        [dss_pkg::DEN_W-1:0]        divisor,
   output dss_pkg::div_status_type                      status
);

   localparam int QW    = dss_pkg::DATA_W;
   localparam int CNT_W = $clog2(QW);
   localparam int RW    = dss_pkg::DEN_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [RW-1:0]     den_ff, den_in;

   logic [dss_pkg::PROD_W-1:0] mag;
   logic [RW:0]                shifted;
   logic [RW+1:0]              diff;
   logic                       fits;

   // One restoring step per cycle; the high half starts below the divisor
   always_comb begin
      mag     = dividend[dss_pkg::PROD_W-1] ? dss_pkg::PROD_W'(-dividend)
                                            : dss_pkg::PROD_W'(dividend);
      shifted = {rem_ff, quo_ff[QW-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !diff[RW+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[dss_pkg::PROD_W-1];
         rem_in  = {1'b0, mag[dss_pkg::PROD_W-1:QW]};
         quo_in  = mag[QW-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[RW-1:0] : shifted[RW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // Apply the dividend sign to the magnitude quotient
   assign status.done     = done_ff;
   assign status.quotient = neg_ff ? $signed(QW'(-quo_ff)) : $signed(quo_ff);

endmodule
`default_nettype wire

// ----- rtl/dss_checker.sv -----
`default_nettype none
`include "decimated_sample_statistics_unit_defines.svh"
module dss_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic                               rsp_accepted,
   input wire logic signed [dss_pkg::DATA_W-1:0]  rsp_mean_value,
   input wire logic signed [dss_pkg::DATA_W-1:0]  rsp_min_value,
   input wire logic signed [dss_pkg::DATA_W-1:0]  rsp_max_value,
   input wire logic        [dss_pkg::DATA_W-1:0]  rsp_kept_count,
   input wire logic signed [dss_pkg::DATA_W-1:0]  rsp_slot_value,
   input wire logic                               rsp_slot_valid
);

   // Block goes busy after taking a transaction
   `DSS_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall,
                   "not busy after accept")

   // Stalled result holds
   `DSS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_mean_value) && $stable(rsp_kept_count),
                   "stalled result changed")

   // Empty statistics read as zero
   `DSS_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && (rsp_kept_count == 0),
                   (rsp_mean_value == 0) && (rsp_min_value == 0) &&
                   (rsp_max_value == 0) && !rsp_accepted,
                   "nonzero statistics with no samples")

   // Kept sample keeps order of extremes and a nonzero count
   `DSS_ASSERT_IMP(a_kept_order, clock, reset, rsp_valid && rsp_accepted,
                   (rsp_kept_count != 0) && (rsp_min_value <= rsp_max_value) &&
                   (rsp_mean_value >= rsp_min_value) && (rsp_mean_value <= rsp_max_value),
                   "statistics out of order")

   // Slot reads zero until the ring wraps
   `DSS_ASSERT_IMP(a_slot_zero, clock, reset, rsp_valid && !rsp_slot_valid,
                   rsp_slot_value == 0, "slot value before wrap")

endmodule

bind decimated_sample_statistics_unit dss_checker u_dss_checker (.*);
`default_nettype wire
